// ===== sv/time_ordered_transfer_queue_search_unit_macros.svh =====
// Assertion macros for the time-ordered transfer queue search unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef TIME_ORDERED_TRANSFER_QUEUE_SEARCH_UNIT_MACROS_SVH
`define TIME_ORDERED_TRANSFER_QUEUE_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold in the same cycle, checked outside reset
`define TOTQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("totq assertion failed");
// Property whose consequent must hold in the cycle after the antecedent
`define TOTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("totq assertion failed");
`else
`define TOTQ_ASSERT(label, clk, rst, prop)
`define TOTQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/totq_pkg.sv =====
// Shared types and constants of the time-ordered transfer queue search unit.
// No dependencies; imported by the interfaces, the cell and the top level.
package totq_pkg;

   localparam int TIME_W  = 16;
   localparam int STN_W   = 8;
   localparam int TYPE_W  = 4;
   localparam int BCNT_W  = 10;
   localparam int OCC_W   = 5;
   localparam int CMD_W   = 2;

   // Command codes on the request word
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   // Control sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // One transfer record
   typedef struct packed {
      logic [TIME_W-1:0] etime;
      logic [STN_W-1:0]  start_stn;
      logic [STN_W-1:0]  end_stn;
      logic [TYPE_W-1:0] btype;
      logic [BCNT_W-1:0] bcount;
   } entry_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      logic              push;
      logic              pop;
      entry_type         new_ent;
      logic [STN_W-1:0]  q_stn;
      logic [TYPE_W-1:0] q_type;
   } cell_ctrl_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [TIME_W-1:0] ftime;
   } tok_type;

   // Response word held in the output register
   typedef struct packed {
      logic              push_refused;
      logic              head_valid;
      entry_type         head;
      logic              found;
      logic [TIME_W-1:0] found_time;
      logic [OCC_W-1:0]  occupancy;
   } rsp_word_type;

endpackage

// ===== sv/totq_req_if.sv =====
// Request channel of the transfer queue: valid/ready handshake and command word.
// Depends on totq_pkg for field widths.
interface totq_req_if import totq_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [TIME_W-1:0] time_req;
   logic [STN_W-1:0]  start_station;
   logic [STN_W-1:0]  end_station;
   logic [TYPE_W-1:0] xfer_type;
   logic [BCNT_W-1:0] bike_count;
   logic [STN_W-1:0]  query_station;
   logic [TYPE_W-1:0] query_type;

   modport source (
      output valid, cmd, time_req, start_station, end_station, xfer_type,
             bike_count, query_station, query_type,
      input  ready
   );

   modport sink (
      input  valid, cmd, time_req, start_station, end_station, xfer_type,
             bike_count, query_station, query_type,
      output ready
   );

endinterface

// ===== sv/totq_rsp_if.sv =====
// Response channel of the transfer queue: valid/ready handshake and result word.
// Depends on totq_pkg for field widths.
interface totq_rsp_if import totq_pkg::*; ();

   logic              valid;
   logic              ready;
   logic              push_refused;
   logic              head_valid;
   logic [TIME_W-1:0] head_time;
   logic [STN_W-1:0]  head_start;
   logic [STN_W-1:0]  head_end;
   logic [TYPE_W-1:0] head_type;
   logic [BCNT_W-1:0] head_count;
   logic              found;
   logic [TIME_W-1:0] found_time;
   logic [OCC_W-1:0]  occupancy;

   modport source (
      output valid, push_refused, head_valid, head_time, head_start, head_end,
             head_type, head_count, found, found_time, occupancy,
      input  ready
   );

   modport sink (
      input  valid, push_refused, head_valid, head_time, head_start, head_end,
             head_type, head_count, found, found_time, occupancy,
      output ready
   );

endinterface

// ===== sv/totq_cell.sv =====
// One slot of the sorted transfer queue: record, valid bit and search token stage.
// Depends on totq_pkg; instantiated in a row by the top level.
module totq_cell import totq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          is_head,
   input  cell_ctrl_type ctrl,
   input  entry_type     prev_ent,
   input  logic          prev_valid,
   input  logic          prev_cond,
   input  entry_type     next_ent,
   input  logic          next_valid,
   input  tok_type       tok_up,
   output entry_type     ent_q,
   output logic          valid_q,
   output logic          cond,
   output entry_type     ent_next,
   output logic          valid_next,
   output tok_type       tok_dn
);

   entry_type         ent_ff;
   logic              valid_ff;
   logic              tok_vld_ff;
   logic              tok_hit_ff;
   logic [TIME_W-1:0] tok_time_ff;

   logic              match;
   logic              tok_hit_in;
   logic [TIME_W-1:0] tok_time_in;

   // New record belongs here or earlier: empty slot, or order test against own time.
   // The head takes only a strictly earlier time; later slots take equal or earlier.
   always_comb begin
      if (!valid_ff) begin
         cond = 1'b1;
      end else if (is_head) begin
         cond = ctrl.new_ent.etime < ent_ff.etime;
      end else begin
         cond = ent_ff.etime >= ctrl.new_ent.etime;
      end
   end

   // Slot update: shift down on push below the insert point, shift up on pop
   always_comb begin
      ent_next   = ent_ff;
      valid_next = valid_ff;
      if (ctrl.push) begin
         if (prev_cond) begin
            ent_next   = prev_ent;
            valid_next = prev_valid;
         end else if (cond) begin
            ent_next   = ctrl.new_ent;
            valid_next = 1'b1;
         end
      end else if (ctrl.pop) begin
         ent_next   = next_ent;
         valid_next = next_valid;
      end
   end

   // Search token stage: first hit in queue order wins
   assign match       = valid_ff && (ent_ff.end_stn == ctrl.q_stn)
                        && (ent_ff.btype == ctrl.q_type);
   assign tok_hit_in  = tok_up.hit || match;
   assign tok_time_in = tok_up.hit ? tok_up.ftime : ent_ff.etime;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_vld_ff <= 1'b0;
         tok_hit_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_next;
         tok_vld_ff <= tok_up.valid;
         tok_hit_ff <= tok_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_next;
      tok_time_ff <= tok_time_in;
   end

   assign ent_q        = ent_ff;
   assign valid_q      = valid_ff;
   assign tok_dn.valid = tok_vld_ff;
   assign tok_dn.hit   = tok_hit_ff;
   assign tok_dn.ftime = tok_time_ff;

endmodule

// ===== sv/time_ordered_transfer_queue_search_unit.sv =====
// Top level of the time-ordered transfer queue with search.
// Depends on totq_pkg, totq_req_if, totq_rsp_if, totq_cell and the macros header.
//
// The queue is a row of DEPTH cells, cell 0 holding the head, kept in time order.
// Push, pop and the unused command code do not leave the idle state: a new word can be
// accepted every cycle while the response register is free or being drained, and
// its response is visible the cycle after acceptance. A push into a full queue is
// dropped and flagged. Search sends a token down the cell row, one cell per cycle;
// the search response is loaded when the token leaves the last cell, and no new
// word is accepted until the response has been loaded.
// Stored records have no reset; only the valid bits, token flags, fill count, state
// and response valid bit are cleared, so there is no clearing pass after reset.
`include "time_ordered_transfer_queue_search_unit_macros.svh"

module time_ordered_transfer_queue_search_unit import totq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   totq_req_if.sink   req_ch,
   totq_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [STN_W-1:0]  qstn_ff;
   logic [TYPE_W-1:0] qtype_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;

   logic              req_ready;
   logic              acc;
   logic              full;
   logic              push_full;
   logic              load_acc;
   logic              load_srch;

   cell_ctrl_type     ctrl;
   tok_type           tok_head;
   entry_type         ent_q      [DEPTH];
   entry_type         ent_next   [DEPTH];
   tok_type           tok_dn     [DEPTH];
   logic [DEPTH-1:0]  valid_vec;
   logic [DEPTH-1:0]  valid_next;
   logic [DEPTH-1:0]  cond;

   assign acc       = req_ch.valid && req_ready;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign push_full = acc && (req_ch.cmd == CMD_PUSH) && full;

   // Broadcast control; the query comes straight from the word in the accept cycle
   always_comb begin
      ctrl.push              = acc && (req_ch.cmd == CMD_PUSH) && !full;
      ctrl.pop               = acc && (req_ch.cmd == CMD_POP);
      ctrl.new_ent.etime     = req_ch.time_req;
      ctrl.new_ent.start_stn = req_ch.start_station;
      ctrl.new_ent.end_stn   = req_ch.end_station;
      ctrl.new_ent.btype     = req_ch.xfer_type;
      ctrl.new_ent.bcount    = req_ch.bike_count;
      ctrl.q_stn             = (state_ff == ST_IDLE) ? req_ch.query_station : qstn_ff;
      ctrl.q_type            = (state_ff == ST_IDLE) ? req_ch.query_type : qtype_ff;
      tok_head.valid         = acc && (req_ch.cmd == CMD_SEARCH);
      tok_head.hit           = 1'b0;
      tok_head.ftime         = '0;
   end

   // Cell row with neighbor links
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type pe, ne;
      logic      pv, pc, nv;
      tok_type   tu;

      if (i == 0) begin : g_first
         assign pe = '0;
         assign pv = 1'b0;
         assign pc = 1'b0;
         assign tu = tok_head;
      end else begin : g_mid
         assign pe = ent_q[i-1];
         assign pv = valid_vec[i-1];
         assign pc = cond[i-1];
         assign tu = tok_dn[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign ne = '0;
         assign nv = 1'b0;
      end else begin : g_inner
         assign ne = ent_q[i+1];
         assign nv = valid_vec[i+1];
      end

      totq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .is_head    ((i == 0) ? 1'b1 : 1'b0),
         .ctrl       (ctrl),
         .prev_ent   (pe),
         .prev_valid (pv),
         .prev_cond  (pc),
         .next_ent   (ne),
         .next_valid (nv),
         .tok_up     (tu),
         .ent_q      (ent_q[i]),
         .valid_q    (valid_vec[i]),
         .cond       (cond[i]),
         .ent_next   (ent_next[i]),
         .valid_next (valid_next[i]),
         .tok_dn     (tok_dn[i])
      );
   end

   // Fill count
   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop && (count_ff != '0)) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && (req_ch.cmd == CMD_SEARCH)) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok_dn[DEPTH-1].valid) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      load_acc  = 1'b0;
      load_srch = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ch.ready;
            load_acc  = acc && (req_ch.cmd != CMD_SEARCH);
         end
         ST_SEARCH: begin
            load_srch = tok_dn[DEPTH-1].valid;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Response word: head after the step, search result, occupancy
   always_comb begin
      rsp_in = '0;
      if (load_srch) begin
         rsp_in.head_valid = valid_vec[0];
         rsp_in.head       = valid_vec[0] ? ent_q[0] : '0;
         rsp_in.found      = tok_dn[DEPTH-1].hit;
         rsp_in.found_time = tok_dn[DEPTH-1].hit ? tok_dn[DEPTH-1].ftime : '0;
         rsp_in.occupancy  = OCC_W'(count_ff);
      end else begin
         rsp_in.push_refused = push_full;
         rsp_in.head_valid   = valid_next[0];
         rsp_in.head         = valid_next[0] ? ent_next[0] : '0;
         rsp_in.occupancy    = OCC_W'(count_in);
      end
   end

   assign rsp_valid_in = (load_acc || load_srch) ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (acc) begin
         qstn_ff  <= req_ch.query_station;
         qtype_ff <= req_ch.query_type;
      end
      if (load_acc || load_srch) begin
         rsp_ff <= rsp_in;
      end
   end

   // Port drive
   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.push_refused = rsp_ff.push_refused;
   assign rsp_ch.head_valid   = rsp_ff.head_valid;
   assign rsp_ch.head_time    = rsp_ff.head.etime;
   assign rsp_ch.head_start   = rsp_ff.head.start_stn;
   assign rsp_ch.head_end     = rsp_ff.head.end_stn;
   assign rsp_ch.head_type    = rsp_ff.head.btype;
   assign rsp_ch.head_count   = rsp_ff.head.bcount;
   assign rsp_ch.found        = rsp_ff.found;
   assign rsp_ch.found_time   = rsp_ff.found_time;
   assign rsp_ch.occupancy    = rsp_ff.occupancy;

   // Checks
   `TOTQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `TOTQ_ASSERT(a_count_matches_valid, clock, reset, CNT_W'($countones(valid_vec)) == count_ff)
   `TOTQ_ASSERT(a_head_order, clock, reset, !valid_vec[1] || (ent_q[0].etime <= ent_q[1].etime))
   `TOTQ_ASSERT(a_token_in_search, clock, reset, !tok_dn[DEPTH-1].valid || (state_ff == ST_SEARCH))
   `TOTQ_ASSERT_NEXT(a_full_push_flag, clock, reset, push_full, rsp_valid_ff && rsp_ff.push_refused)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the time-ordered transfer queue search unit: directed and
// random command words, a queue-ordered predictor and a field-by-field response check.
// Depends on totq_pkg, totq_req_if, totq_rsp_if and the unit's RTL.
module tb_top;
   import totq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_WORDS = 400;
   localparam int CALM_TAIL = 60;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // One request word as the bench builds it
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [TIME_W-1:0] tstamp;
      logic [STN_W-1:0]  src_stn;
      logic [STN_W-1:0]  dst_stn;
      logic [TYPE_W-1:0] btype;
      logic [BCNT_W-1:0] bcount;
      logic [STN_W-1:0]  q_stn;
      logic [TYPE_W-1:0] q_type;
   } xfer_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   totq_req_if req_if ();
   totq_rsp_if rsp_if ();

   time_ordered_transfer_queue_search_unit #(
      .DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #10 clock = ~clock;

   xfer_cmd_type cmd_backlog_q[$];      // words waiting for the driver
   rsp_word_type expected_status_q[$];  // predicted responses, oldest first
   entry_type    sched_q[$];            // predicted queue contents, head first
   logic [STN_W+TYPE_W-1:0] recent_keys[$];
   int           gen_fill = 0;
   int           words_sent = 0;
   int           error_count = 0;
   int           req_gap = 0;
   int           rsp_stall = 0;
   logic         req_fired = 1'b0;
   xfer_cmd_type drv_word;

   // Predicted effect of one accepted word on the queue, and the response it gives
   function automatic rsp_word_type step_transfer_queue(xfer_cmd_type c);
      rsp_word_type r;
      entry_type rec;
      int pos;
      int n;
      r = '0;
      n = sched_q.size();
      rec.etime = c.tstamp;
      rec.start_stn = c.src_stn;
      rec.end_stn = c.dst_stn;
      rec.btype = c.btype;
      rec.bcount = c.bcount;
      case (c.cmd)
         CMD_PUSH: begin
            if (n >= QUEUE_DEPTH) begin
               r.push_refused = 1'b1;
            end else begin
               // earlier than head: new head; else before first later-or-equal past head
               pos = n;
               if (n == 0 || c.tstamp < sched_q[0].etime) begin
                  pos = 0;
               end else begin
                  for (int i = 1; i < n; i++)
                     if (pos == n && sched_q[i].etime >= c.tstamp) pos = i;
               end
               sched_q.insert(pos, rec);
            end
         end
         CMD_POP: begin
            if (n > 0) void'(sched_q.pop_front());
         end
         CMD_SEARCH: begin
            for (int i = 0; i < n; i++)
               if (!r.found && sched_q[i].end_stn == c.q_stn && sched_q[i].btype == c.q_type)
               begin
                  r.found = 1'b1;
                  r.found_time = sched_q[i].etime;
               end
         end
         default: ;
      endcase
      if (sched_q.size() > 0) begin
         r.head_valid = 1'b1;
         r.head = sched_q[0];
      end
      r.occupancy = OCC_W'(sched_q.size());
      return r;
   endfunction

   task automatic check_field(string fld, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
      end
   endtask

   function automatic xfer_cmd_type push_word(logic [TIME_W-1:0] t, logic [STN_W-1:0] s,
                                              logic [STN_W-1:0] e, logic [TYPE_W-1:0] ty,
                                              logic [BCNT_W-1:0] cnt);
      xfer_cmd_type w;
      w = '0;
      w.cmd = CMD_PUSH;
      w.tstamp = t;
      w.src_stn = s;
      w.dst_stn = e;
      w.btype = ty;
      w.bcount = cnt;
      return w;
   endfunction

   function automatic xfer_cmd_type plain_word(logic [CMD_W-1:0] c, logic [STN_W-1:0] qs,
                                               logic [TYPE_W-1:0] qt);
      xfer_cmd_type w;
      w = '0;
      w.cmd = c;
      w.q_stn = qs;
      w.q_type = qt;
      return w;
   endfunction

   // Queue a word for the driver; track fill and stored keys to steer later words
   task automatic enqueue_word(xfer_cmd_type w);
      cmd_backlog_q.push_back(w);
      if (w.cmd == CMD_PUSH && gen_fill < QUEUE_DEPTH) begin
         gen_fill++;
         recent_keys.push_back({w.dst_stn, w.btype});
         if (recent_keys.size() > QUEUE_DEPTH) void'(recent_keys.pop_front());
      end else if (w.cmd == CMD_POP && gen_fill > 0) begin
         gen_fill--;
      end
   endtask

   // Idling runs in stretches and stops for the tail of the run
   function automatic bit idling_on();
      return cmd_backlog_q.size() > CALM_TAIL && ((words_sent / 50) % 4) != 3;
   endfunction

   // Request driver: words change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_fired) begin
         // hold the word until it is taken
      end else if (req_gap > 0) begin
         req_if.valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (cmd_backlog_q.size() > 0) begin
         drv_word = cmd_backlog_q.pop_front();
         words_sent++;
         req_if.cmd <= drv_word.cmd;
         req_if.time_req <= drv_word.tstamp;
         req_if.start_station <= drv_word.src_stn;
         req_if.end_station <= drv_word.dst_stn;
         req_if.xfer_type <= drv_word.btype;
         req_if.bike_count <= drv_word.bcount;
         req_if.query_station <= drv_word.q_stn;
         req_if.query_type <= drv_word.q_type;
         req_if.valid <= 1'b1;
         if (idling_on() && $urandom_range(0, 3) == 0) req_gap <= $urandom_range(1, 5);
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Response side backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (idling_on() && $urandom_range(0, 4) == 0) rsp_stall <= $urandom_range(1, 5);
      end
   end

   // Monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin : monitor
      xfer_cmd_type seen;
      rsp_word_type want;
      req_fired <= req_if.valid && req_if.ready;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen.cmd = req_if.cmd;
            seen.tstamp = req_if.time_req;
            seen.src_stn = req_if.start_station;
            seen.dst_stn = req_if.end_station;
            seen.btype = req_if.xfer_type;
            seen.bcount = req_if.bike_count;
            seen.q_stn = req_if.query_station;
            seen.q_type = req_if.query_type;
            expected_status_q.push_back(step_transfer_queue(seen));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_status_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: response word with nothing expected", $time);
            end else begin
               want = expected_status_q.pop_front();
               check_field("push_refused", 32'(want.push_refused), 32'(rsp_if.push_refused));
               check_field("head_valid", 32'(want.head_valid), 32'(rsp_if.head_valid));
               check_field("head_time", 32'(want.head.etime), 32'(rsp_if.head_time));
               check_field("head_start", 32'(want.head.start_stn), 32'(rsp_if.head_start));
               check_field("head_end", 32'(want.head.end_stn), 32'(rsp_if.head_end));
               check_field("head_type", 32'(want.head.btype), 32'(rsp_if.head_type));
               check_field("head_count", 32'(want.head.bcount), 32'(rsp_if.head_count));
               check_field("found", 32'(want.found), 32'(rsp_if.found));
               check_field("found_time", 32'(want.found_time), 32'(rsp_if.found_time));
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_if.occupancy));
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      xfer_cmd_type w;
      int mode;
      int roll;
      int push_pct;
      int pop_pct;
      logic [STN_W+TYPE_W-1:0] key;

      req_if.valid = 1'b0;
      req_if.cmd = '0;
      req_if.time_req = '0;
      req_if.start_station = '0;
      req_if.end_station = '0;
      req_if.xfer_type = '0;
      req_if.bike_count = '0;
      req_if.query_station = '0;
      req_if.query_type = '0;
      rsp_if.ready = 1'b0;

      // Directed: empty-queue commands, head placement, hit and miss, full queue
      enqueue_word(plain_word(CMD_POP, 8'h00, 4'h0));
      enqueue_word(plain_word(CMD_SEARCH, 8'hFF, 4'hF));
      enqueue_word(plain_word(CMD_UNUSED, 8'h00, 4'h0));
      enqueue_word(push_word(16'hFFFF, 8'hFF, 8'hFF, 4'hF, 10'h3FF));
      enqueue_word(push_word(16'h0000, 8'h00, 8'h00, 4'h0, 10'h000));
      // same time as the head: goes behind it
      enqueue_word(push_word(16'h0000, 8'h12, 8'h34, 4'h5, 10'h155));
      enqueue_word(push_word(16'h8000, 8'hAA, 8'h55, 4'hA, 10'h2AA));
      enqueue_word(plain_word(CMD_SEARCH, 8'hFF, 4'hF));
      enqueue_word(plain_word(CMD_SEARCH, 8'h34, 4'h6));
      w = push_word(16'hFFFF, 8'hFF, 8'hFF, 4'hF, 10'h3FF);
      w.cmd = CMD_UNUSED;
      w.q_stn = 8'hFF;
      w.q_type = 4'hF;
      enqueue_word(w);
      for (int i = 0; i < 12; i++)
         enqueue_word(push_word(16'h4000 + 16'(i * 7), 8'(i), 8'(i), 4'(i), 10'(i * 80)));
      // queue is full here: refused
      enqueue_word(push_word(16'h0001, 8'h01, 8'h02, 4'h3, 10'h004));
      enqueue_word(plain_word(CMD_SEARCH, 8'h00, 4'h0));
      enqueue_word(plain_word(CMD_POP, 8'h00, 4'h0));

      // Random: phases that lean to filling, draining or a mix
      mode = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 30 == 0) mode = $urandom_range(0, 2);
         push_pct = (mode == 1) ? 70 : (mode == 2) ? 20 : 40;
         pop_pct = (mode == 1) ? 15 : (mode == 2) ? 60 : 30;
         w.src_stn = STN_W'($urandom_range(0, 255));
         w.bcount = BCNT_W'($urandom_range(0, 1023));
         roll = $urandom_range(0, 99);
         if (roll < 40) w.tstamp = TIME_W'($urandom_range(0, 65535));
         else if (roll < 80) w.tstamp = TIME_W'($urandom_range(0, 31));
         else if (roll < 90) w.tstamp = '0;
         else w.tstamp = '1;
         // few distinct keys so several entries match and order matters
         if ($urandom_range(0, 1) == 0) begin
            w.dst_stn = STN_W'($urandom_range(0, 3));
            w.btype = TYPE_W'($urandom_range(0, 3));
         end else begin
            w.dst_stn = STN_W'($urandom_range(0, 255));
            w.btype = TYPE_W'($urandom_range(0, 15));
         end
         if (recent_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
            key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            {w.q_stn, w.q_type} = key;
         end else begin
            w.q_stn = STN_W'($urandom_range(0, 255));
            w.q_type = TYPE_W'($urandom_range(0, 15));
         end
         roll = $urandom_range(0, 99);
         if (roll < push_pct) w.cmd = CMD_PUSH;
         else if (roll < push_pct + pop_pct) w.cmd = CMD_POP;
         else if (roll < 97) w.cmd = CMD_SEARCH;
         else w.cmd = CMD_UNUSED;
         enqueue_word(w);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_backlog_q.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_status_q.size() > 0) @(posedge clock);
      // a search walks the whole cell row before it answers
      repeat (2 * QUEUE_DEPTH + 8) @(posedge clock);

      if (error_count == 0 && expected_status_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
